[rtl/swtbs_pkg.sv]
package swtbs_pkg;

  localparam int unsigned CFG_W = 9;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] entry_index;
    logic [3:0] char_pos;
    logic [7:0] char_value;
    logic       last_char;
  } req_t;

  typedef struct packed {
    logic       found;
    logic [7:0] match_index;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MID,
    ST_SCAN,
    ST_DONE
  } search_state_t;

endpackage

[rtl/sorted_word_table_binary_search.sv]
// Channel   Direction  Handshake             Payload
// request   in         in_valid / in_stall   in_req  (swtbs_pkg::req_t)
// result    out        out_valid / out_stall out_rsp (swtbs_pkg::rsp_t)
// config    in         cfg_we                cfg_data (entry_count)
//
// Load items and query bytes without last_char are written to the store or query buffer when accepted.
// A search makes P probes (up to ceil(log2(count + 1))) of B byte reads each
// (up to WORD_LEN), one store byte per cycle from the single word store port.
// Requests stall during a search; a pending result does not block new requests
// once it sits in the output register. Synchronous reset, no clearing pass.
module sorted_word_table_binary_search #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned WORD_LEN    = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  swtbs_pkg::req_t             in_req,
  output logic                        out_valid,
  input  logic                        out_stall,
  output swtbs_pkg::rsp_t             out_rsp,
  input  logic                        cfg_we,
  input  logic [swtbs_pkg::CFG_W-1:0] cfg_data
);

  localparam int unsigned QW = $clog2(WORD_LEN);
  localparam int unsigned SA = $clog2(TABLE_DEPTH * WORD_LEN);

  logic [swtbs_pkg::CFG_W-1:0] entry_count;
  logic          accept;
  logic          pos_ok;
  logic          store_we;
  logic          query_we;
  logic          start;
  logic          busy;
  logic          rd_en;
  logic          qclr;
  logic [SA-1:0] store_waddr;
  logic [SA-1:0] store_raddr;
  logic [QW-1:0] query_waddr;
  logic [QW-1:0] query_raddr;
  logic [7:0]    store_byte;
  logic [7:0]    query_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_we) begin
      entry_count <= cfg_data;
    end
  end

  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;
  assign pos_ok   = 32'(in_req.char_pos) < WORD_LEN;
  assign store_we = accept && in_req.func == swtbs_pkg::FUNC_LOAD && pos_ok
                    && 32'(in_req.entry_index) < TABLE_DEPTH;
  assign query_we = accept && in_req.func == swtbs_pkg::FUNC_QUERY && pos_ok;
  assign start    = accept && in_req.func == swtbs_pkg::FUNC_QUERY && in_req.last_char;

  assign store_waddr = SA'(32'(in_req.entry_index) * WORD_LEN + 32'(in_req.char_pos));
  assign query_waddr = QW'(32'(in_req.char_pos));

  swtbs_store #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .WORD_LEN   (WORD_LEN)
  ) u_store (
    .clk  (clk),
    .we   (store_we),
    .waddr(store_waddr),
    .wdata(in_req.char_value),
    .re   (rd_en),
    .raddr(store_raddr),
    .rdata(store_byte)
  );

  swtbs_qbuf #(
    .WORD_LEN(WORD_LEN)
  ) u_qbuf (
    .clk  (clk),
    .rst  (rst),
    .clr  (qclr),
    .we   (query_we),
    .waddr(query_waddr),
    .wdata(in_req.char_value),
    .re   (rd_en),
    .raddr(query_raddr),
    .rdata(query_byte)
  );

  swtbs_search #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .WORD_LEN   (WORD_LEN)
  ) u_search (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .entry_count(entry_count),
    .store_byte (store_byte),
    .query_byte (query_byte),
    .out_stall  (out_stall),
    .busy       (busy),
    .rd_en      (rd_en),
    .store_addr (store_raddr),
    .query_addr (query_raddr),
    .qclr       (qclr),
    .out_valid  (out_valid),
    .out_rsp    (out_rsp)
  );

`ifndef NO_ASSERTIONS
  a_miss_zero_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_rsp.found |-> out_rsp.match_index == 8'd0)
    else $error("miss with nonzero index");

  a_hit_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_rsp.found |-> {1'b0, out_rsp.match_index} < entry_count)
    else $error("hit index beyond entry count");

  a_result_after_search: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(busy))
    else $error("result without a search");

  a_no_store_write_in_search: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> !store_we && !query_we)
    else $error("memory write during search");
`endif

endmodule

[rtl/swtbs_store.sv]
module swtbs_store #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned WORD_LEN    = 16,
  localparam int unsigned SA = $clog2(TABLE_DEPTH * WORD_LEN)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [SA-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [SA-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [TABLE_DEPTH * WORD_LEN];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/swtbs_qbuf.sv]
module swtbs_qbuf #(
  parameter int unsigned WORD_LEN = 16,
  localparam int unsigned QW = $clog2(WORD_LEN)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          clr,
  input  logic          we,
  input  logic [QW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [QW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0]          mem [WORD_LEN];
  logic [WORD_LEN-1:0] vld;
  logic [7:0]          rd_dat;
  logic                rd_vld;

  // unwritten bytes read as zero
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_dat <= mem[raddr];
      rd_vld <= vld[raddr];
    end
  end

  assign rdata = rd_vld ? rd_dat : 8'd0;

endmodule

[rtl/swtbs_search.sv]
module swtbs_search #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned WORD_LEN    = 16,
  localparam int unsigned AW = $clog2(TABLE_DEPTH),
  localparam int unsigned NW = $clog2(TABLE_DEPTH + 1),
  localparam int unsigned QW = $clog2(WORD_LEN),
  localparam int unsigned SA = $clog2(TABLE_DEPTH * WORD_LEN)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [swtbs_pkg::CFG_W-1:0]  entry_count,
  input  logic [7:0]                   store_byte,
  input  logic [7:0]                   query_byte,
  input  logic                         out_stall,
  output logic                         busy,
  output logic                         rd_en,
  output logic [SA-1:0]                store_addr,
  output logic [QW-1:0]                query_addr,
  output logic                         qclr,
  output logic                         out_valid,
  output swtbs_pkg::rsp_t              out_rsp
);

  swtbs_pkg::search_state_t state, state_next;

  logic [NW-1:0] low;
  logic [NW-1:0] hi;
  logic [AW-1:0] mid;
  logic [SA-1:0] base;
  logic [QW-1:0] rd_idx;
  logic          rd_more;
  logic          pipe_v;
  logic          pipe_last;
  logic          hit;

  logic [NW-1:0] count_sat;
  logic [NW:0]   mid_sum;
  logic [AW-1:0] mid_calc;
  logic          range_empty;
  logic          byte_ne;
  logic          byte_eq_end;
  logic          out_free;
  logic          load_out;

  assign count_sat = (32'(entry_count) > TABLE_DEPTH) ? NW'(TABLE_DEPTH) : NW'(entry_count);
  assign mid_sum   = {1'b0, low} + {1'b0, hi} - (NW + 1)'(1);
  assign mid_calc  = AW'(mid_sum >> 1);
  assign range_empty = (low >= hi);

  assign byte_ne     = pipe_v && (store_byte != query_byte);
  assign byte_eq_end = pipe_v && (store_byte == query_byte)
                       && ((store_byte == 8'd0) || pipe_last);
  assign out_free    = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      swtbs_pkg::ST_IDLE: begin
        if (start) state_next = swtbs_pkg::ST_MID;
      end
      swtbs_pkg::ST_MID: begin
        state_next = range_empty ? swtbs_pkg::ST_DONE : swtbs_pkg::ST_SCAN;
      end
      swtbs_pkg::ST_SCAN: begin
        if (byte_ne) begin
          state_next = swtbs_pkg::ST_MID;
        end else if (byte_eq_end) begin
          state_next = swtbs_pkg::ST_DONE;
        end
      end
      swtbs_pkg::ST_DONE: begin
        if (out_free) state_next = swtbs_pkg::ST_IDLE;
      end
      default: state_next = swtbs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy     = 1'b1;
    rd_en    = 1'b0;
    qclr     = 1'b0;
    load_out = 1'b0;
    case (state)
      swtbs_pkg::ST_IDLE: busy = 1'b0;
      swtbs_pkg::ST_MID:  ;
      swtbs_pkg::ST_SCAN: rd_en = rd_more;
      swtbs_pkg::ST_DONE: begin
        load_out = out_free;
        qclr     = out_free;
      end
      default: ;
    endcase
  end

  assign store_addr = base + SA'(rd_idx);
  assign query_addr = rd_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swtbs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_more <= 1'b0;
      pipe_v  <= 1'b0;
    end else if (state == swtbs_pkg::ST_MID) begin
      rd_more <= !range_empty;
      pipe_v  <= 1'b0;
    end else if (state == swtbs_pkg::ST_SCAN && !byte_ne && !byte_eq_end) begin
      pipe_v <= rd_more;
      if (rd_more && rd_idx == QW'(WORD_LEN - 1)) rd_more <= 1'b0;
    end else begin
      rd_more <= 1'b0;
      pipe_v  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      swtbs_pkg::ST_IDLE: begin
        low <= '0;
        hi  <= count_sat;
        hit <= 1'b0;
      end
      swtbs_pkg::ST_MID: begin
        mid    <= mid_calc;
        base   <= SA'(32'(mid_calc) * WORD_LEN);
        rd_idx <= '0;
      end
      swtbs_pkg::ST_SCAN: begin
        if (rd_more) begin
          rd_idx    <= rd_idx + QW'(1);
          pipe_last <= (rd_idx == QW'(WORD_LEN - 1));
        end
        if (byte_ne) begin
          if (store_byte < query_byte) begin
            low <= NW'(mid) + NW'(1);
          end else begin
            hi <= NW'(mid);
          end
        end else if (byte_eq_end) begin
          hit <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_rsp.found       <= hit;
      out_rsp.match_index <= hit ? 8'(mid) : 8'd0;
    end
  end

endmodule
